/* hdl/kdax_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdax_pkg: shared types and constants of the KISS deframer
// Buffer sizing, KISS byte codes, the command word passed from the front end
// to the back end, and the result word held in the output queue.
// ----------------------------------------------------------------------------
package kdax_pkg;

  // Bytes per bank of the frame store, command byte included.
  localparam int BUF_BYTES = 4096;
  localparam int FC_W      = $clog2(BUF_BYTES + 1);
  localparam int MEM_DEPTH = 2 * BUF_BYTES;
  localparam int MA_W      = $clog2(MEM_DEPTH);

  localparam int IDX_W  = 12;
  localparam int LEN_W  = 12;
  localparam int POFF_W = 5;
  localparam int CMP_W  = (FC_W > IDX_W) ? FC_W : IDX_W;

  // Command queue between front end and back end.
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  // Output queue inside the back end.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // KISS special bytes.
  localparam logic [7:0] K_FEND  = 8'hC0;
  localparam logic [7:0] K_FESC  = 8'hDB;
  localparam logic [7:0] K_TFEND = 8'hDC;
  localparam logic [7:0] K_TFESC = 8'hDD;

  // AX.25 UI header: length, control byte and PID expected at bytes 14, 15.
  localparam int          HDR_LEN  = 16;
  localparam int          CTL_POS  = 14;
  localparam int          PID_POS  = 15;
  localparam logic [15:0] UI_CPID  = 16'h03F0;

  // Request codes of the input word.
  localparam logic REQ_RX   = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_REPORT
  } cmd_kind_t;

  typedef enum logic [0:0] {
    RES_REPORT = 1'b0,
    RES_READ   = 1'b1
  } res_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [MA_W-1:0]  addr;
    logic [7:0]       data;
    logic             hit;
    logic [LEN_W-1:0] flen;
    logic             ax;
    logic [LEN_W-1:0] plen;
  } cmd_t;

  typedef struct packed {
    res_kind_t         kind;
    logic [LEN_W-1:0]  flen;
    logic              ax;
    logic [POFF_W-1:0] poff;
    logic [LEN_W-1:0]  plen;
    logic [7:0]        rdata;
  } res_t;

endpackage

/* hdl/kdax_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdax_front: KISS deframing front end
// Tracks framing and escape state, turns each accepted word into at most one
// command (store write, store read, or frame report) for the back end.
// ----------------------------------------------------------------------------
module kdax_front
  import kdax_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             req_type,
  input  logic [7:0]       rx_byte,
  input  logic [IDX_W-1:0] read_index,
  output logic             cmd_push,
  output cmd_t             cmd
);

  logic            in_frame_r, in_frame_nxt;
  logic            esc_r, esc_nxt;
  logic [FC_W-1:0] fill_r, fill_nxt;
  logic [3:0]      cmd_nib_r, cmd_nib_nxt;
  logic [15:0]     cpid_r, cpid_nxt;
  logic            bank_r, bank_nxt;
  logic [FC_W-1:0] done_len_r, done_len_nxt;

  logic            store;
  logic [7:0]      byte_val;
  logic [FC_W-1:0] fl;
  logic [FC_W-1:0] pos;
  logic            ax;
  logic [MA_W-1:0] fill_base;
  logic [MA_W-1:0] read_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      fill_r     <= '0;
      cmd_nib_r  <= '0;
      cpid_r     <= '0;
      bank_r     <= 1'b0;
      done_len_r <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      fill_r     <= fill_nxt;
      cmd_nib_r  <= cmd_nib_nxt;
      cpid_r     <= cpid_nxt;
      bank_r     <= bank_nxt;
      done_len_r <= done_len_nxt;
    end
  end

  assign fl        = fill_r - FC_W'(1);
  assign pos       = fill_r - FC_W'(1);
  assign ax        = (fl > FC_W'(HDR_LEN)) && (cpid_r == UI_CPID);
  assign fill_base = bank_r ? MA_W'(BUF_BYTES) : '0;
  assign read_base = bank_r ? '0 : MA_W'(BUF_BYTES);

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    fill_nxt     = fill_r;
    cmd_nib_nxt  = cmd_nib_r;
    cpid_nxt     = cpid_r;
    bank_nxt     = bank_r;
    done_len_nxt = done_len_r;
    store        = 1'b0;
    byte_val     = rx_byte;
    cmd_push     = 1'b0;
    cmd          = '0;
    cmd.kind     = CMD_WRITE;

    if (accept) begin
      if (req_type == REQ_READ) begin
        cmd_push = 1'b1;
        cmd.kind = CMD_READ;
        cmd.hit  = CMP_W'(read_index) < CMP_W'(done_len_r);
        cmd.addr = read_base + MA_W'(read_index);
      end else if (rx_byte == K_FEND) begin
        // A closing delimiter delivers the frame if it is a data frame
        // holding at least one byte; every delimiter opens a new frame.
        if (in_frame_r && (fill_r > FC_W'(1)) && (cmd_nib_r == 4'h0)) begin
          cmd_push     = 1'b1;
          cmd.kind     = CMD_REPORT;
          cmd.flen     = LEN_W'(fl);
          cmd.ax       = ax;
          cmd.plen     = ax ? LEN_W'(fl - FC_W'(HDR_LEN)) : LEN_W'(fl);
          done_len_nxt = fl;
          bank_nxt     = ~bank_r;
        end
        in_frame_nxt = 1'b1;
        esc_nxt      = 1'b0;
        fill_nxt     = '0;
        cpid_nxt     = '0;
      end else if (in_frame_r) begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          store   = 1'b1;
          case (rx_byte)
            K_TFEND: byte_val = K_FEND;
            K_TFESC: byte_val = K_FESC;
            default: byte_val = rx_byte;
          endcase
        end else if (rx_byte == K_FESC) begin
          esc_nxt = 1'b1;
        end else begin
          store = 1'b1;
        end

        // Bytes past the end of the bank are dropped silently.
        if (store && (fill_r < FC_W'(BUF_BYTES))) begin
          if (fill_r == '0) begin
            cmd_nib_nxt = byte_val[3:0];
          end else begin
            cmd_push = 1'b1;
            cmd.kind = CMD_WRITE;
            cmd.addr = fill_base + MA_W'(pos);
            cmd.data = byte_val;
            if (pos == FC_W'(CTL_POS)) begin
              cpid_nxt[15:8] = byte_val;
            end else if (pos == FC_W'(PID_POS)) begin
              cpid_nxt[7:0] = byte_val;
            end
          end
          fill_nxt = fill_r + FC_W'(1);
        end
      end
    end
  end

endmodule

/* hdl/kdax_cmdq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdax_cmdq: command queue
// Short first-in first-out queue of commands between front end and back end.
// ----------------------------------------------------------------------------
module kdax_cmdq
  import kdax_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic valid,
  output cmd_t head
);

  cmd_t             slot_r [CQ_DEPTH];
  logic [CQ_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CQ_CW'(CQ_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CQ_PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + CQ_PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CQ_PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + CQ_PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CQ_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hdl/kdax_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdax_back: frame store and result back end
// Executes commands in order against the double-banked frame store, builds
// result words and queues them for the output side.
// ----------------------------------------------------------------------------
module kdax_back
  import kdax_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_valid,
  output res_t out_res,
  input  logic out_pop
);

  logic [7:0]       mem [MEM_DEPTH];
  logic [7:0]       mem_q_r;

  logic             stage_valid_r, stage_valid_nxt;
  cmd_t             stage_r;
  res_t             stage_res;

  res_t             oq_r [OQ_DEPTH];
  logic [OQ_PW-1:0] oq_wr_r, oq_wr_nxt;
  logic [OQ_PW-1:0] oq_rd_r, oq_rd_nxt;
  logic [OQ_CW-1:0] oq_count_r, oq_count_nxt;
  logic [OQ_CW-1:0] oq_busy;
  logic             oq_push;
  logic             oq_take;
  logic             mem_we;

  // A command that yields a result only leaves the queue when the output
  // queue is sure to have a slot for it once it is staged.
  assign oq_busy = oq_count_r + OQ_CW'(stage_valid_r);
  assign cmd_pop = cmd_valid &&
                   ((cmd.kind == CMD_WRITE) || (oq_busy < OQ_CW'(OQ_DEPTH)));
  assign mem_we  = cmd_pop && (cmd.kind == CMD_WRITE);
  assign stage_valid_nxt = cmd_pop && (cmd.kind != CMD_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.addr] <= cmd.data;
    end
    mem_q_r <= mem[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      stage_r <= cmd;
    end
  end

  always_comb begin
    stage_res = '0;
    if (stage_r.kind == CMD_READ) begin
      stage_res.kind  = RES_READ;
      stage_res.rdata = stage_r.hit ? mem_q_r : 8'h00;
    end else begin
      stage_res.kind = RES_REPORT;
      stage_res.flen = stage_r.flen;
      stage_res.ax   = stage_r.ax;
      stage_res.poff = stage_r.ax ? POFF_W'(HDR_LEN) : '0;
      stage_res.plen = stage_r.plen;
    end
  end

  assign oq_push   = stage_valid_r;
  assign out_valid = (oq_count_r != '0);
  assign out_res   = oq_r[oq_rd_r];
  assign oq_take   = out_pop && out_valid;

  always_comb begin
    oq_wr_nxt    = oq_wr_r;
    oq_rd_nxt    = oq_rd_r;
    oq_count_nxt = oq_count_r;
    if (oq_push) begin
      oq_wr_nxt = (oq_wr_r == OQ_PW'(OQ_DEPTH - 1)) ? '0 : oq_wr_r + OQ_PW'(1);
    end
    if (oq_take) begin
      oq_rd_nxt = (oq_rd_r == OQ_PW'(OQ_DEPTH - 1)) ? '0 : oq_rd_r + OQ_PW'(1);
    end
    if (oq_push && !oq_take) begin
      oq_count_nxt = oq_count_r + OQ_CW'(1);
    end else if (oq_take && !oq_push) begin
      oq_count_nxt = oq_count_r - OQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      oq_wr_r       <= '0;
      oq_rd_r       <= '0;
      oq_count_r    <= '0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      oq_wr_r       <= oq_wr_nxt;
      oq_rd_r       <= oq_rd_nxt;
      oq_count_r    <= oq_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= stage_res;
    end
  end

  // The staged result always finds a free slot in the output queue.
  a_stage_fits: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r |-> (oq_count_r < OQ_CW'(OQ_DEPTH)))
    else $error("output queue overflow");

  // A read or report command taken from the queue is staged next cycle.
  a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && (cmd.kind != CMD_WRITE)) |=> stage_valid_r)
    else $error("result command not staged");

  // Store writes never produce a staged result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && (cmd.kind == CMD_WRITE)) |=> !stage_valid_r)
    else $error("store write produced a result");

  // Occupancy never exceeds the queue depth.
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_count_r <= OQ_CW'(OQ_DEPTH))
    else $error("output queue count out of range");

endmodule

/* hdl/kiss_deframer_ax25_strip.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kiss_deframer_ax25_strip: KISS deframer with AX.25 UI header detection
// Removes KISS framing from serial bytes into a double-banked frame store,
// reports completed frames and answers byte reads of the last frame.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake        Word
//   -------  ---------------  ---------------------------------------------
//   input    push / full      in_req_type, in_rx_byte, in_read_index
//   result   empty / pop      out_result_kind, out_frame_length, out_is_ax25,
//                             out_payload_offset, out_payload_length,
//                             out_read_data
//
// One input word is accepted per cycle while the command queue has room. Each
// word becomes at most one command to the back end, which executes one command
// per cycle on the frame store's single port unless a result command waits
// for output queue room. A result is staged, then queued for the output ports.
// Reset clears framing state and queues; the frame store has no reset and no
// clearing pass, and is only read at positions of a frame already written.
// full rises when the four-entry command queue fills, which happens only
// while the result side holds pop low.
// ----------------------------------------------------------------------------
module kiss_deframer_ax25_strip
  import kdax_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              push,
  output logic              full,
  input  logic              in_req_type,
  input  logic [7:0]        in_rx_byte,
  input  logic [IDX_W-1:0]  in_read_index,

  output logic              empty,
  input  logic              pop,
  output logic              out_result_kind,
  output logic [LEN_W-1:0]  out_frame_length,
  output logic              out_is_ax25,
  output logic [POFF_W-1:0] out_payload_offset,
  output logic [LEN_W-1:0]  out_payload_length,
  output logic [7:0]        out_read_data
);

  logic accept;
  logic fe_push;
  cmd_t fe_cmd;
  logic cq_full;
  logic cq_valid;
  cmd_t cq_head;
  logic cq_pop;
  logic res_valid;
  res_t res;

  // Words are taken whenever the command queue has room.
  assign full   = cq_full;
  assign accept = push && !cq_full;

  // Front end: framing, escapes, fill counting and bank selection.
  kdax_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req_type   (in_req_type),
    .rx_byte    (in_rx_byte),
    .read_index (in_read_index),
    .cmd_push   (fe_push),
    .cmd        (fe_cmd)
  );

  // Commands keep their order, so a read always sees the bank as it stood
  // when the read word was accepted.
  kdax_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_push),
    .push_cmd (fe_cmd),
    .pop      (cq_pop),
    .full     (cq_full),
    .valid    (cq_valid),
    .head     (cq_head)
  );

  // Back end: frame store access and the output queue.
  kdax_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cq_valid),
    .cmd       (cq_head),
    .cmd_pop   (cq_pop),
    .out_valid (res_valid),
    .out_res   (res),
    .out_pop   (pop)
  );

  assign empty              = !res_valid;
  assign out_result_kind    = res.kind;
  assign out_frame_length   = res.flen;
  assign out_is_ax25        = res.ax;
  assign out_payload_offset = res.poff;
  assign out_payload_length = res.plen;
  assign out_read_data      = res.rdata;

endmodule
